FILE: rtl/pcnb_pkg.sv
// ----------------------------------------------------------------------------
// pcnb_pkg
// shared widths, reset values and register indexes of the cell neighbor unit
// ----------------------------------------------------------------------------
package pcnb_pkg;

    localparam int CELLS_MAX_DEF = 64;
    localparam int POS_W         = 32;
    localparam int BOX_W         = 32;
    localparam int CREG_W        = 7;
    localparam int IDX_W         = 18;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int MAX_RESULTS   = 27;

    localparam logic [CREG_W-1:0] CELLS_RST = CREG_W'(1);
    localparam logic [BOX_W-1:0]  BOX_RST   = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELLS_X = 3'd0,
        CFG_CELLS_Y = 3'd1,
        CFG_CELLS_Z = 3'd2,
        CFG_BOX_X   = 3'd3,
        CFG_BOX_Y   = 3'd4,
        CFG_BOX_Z   = 3'd5
    } t_cfg_reg;

endpackage

FILE: rtl/pcnb_axis_div.sv
// ----------------------------------------------------------------------------
// pcnb_axis_div
// home cell of one axis: floor(cells*pos/box) clamped to cells-1, pipelined
// ----------------------------------------------------------------------------
module pcnb_axis_div #(
    parameter int CELLS_MAX = pcnb_pkg::CELLS_MAX_DEF,
    localparam int CW = $clog2(CELLS_MAX + 1),
    localparam int QW = (CELLS_MAX > 1) ? $clog2(CELLS_MAX) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [pcnb_pkg::POS_W-1:0] i_pos,
    input  logic [CW-1:0]              i_cells,
    input  logic [pcnb_pkg::BOX_W-1:0] i_box,
    output logic [QW-1:0]              o_home
);
    import pcnb_pkg::*;

    localparam int NW = CW + POS_W;
    localparam int DW = NW + 1;

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_rem [QW];
    logic [QW-1:0] r_q   [QW];
    logic          r_ovf [QW];
    logic [QW-1:0] r_home;
    logic [QW-1:0] h_sat;
    logic [CW-1:0] cm1;

    // numerator
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= NW'(i_cells) * NW'(i_pos);
        end
    end

    // one restoring step per stage, msb first
    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [NW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic          ovf_in;
        logic [DW-1:0] dsr;
        logic          ge;

        if (j == 0) begin : g_first
            // quotient would not fit the result width
            assign rem_in = r_num;
            assign q_in   = '0;
            assign ovf_in = ({1'b0, r_num} >= (DW'(i_box) << QW));
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign ovf_in = r_ovf[j-1];
        end

        assign dsr = DW'(i_box) << (QW - 1 - j);
        assign ge  = ({1'b0, rem_in} >= dsr);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? NW'({1'b0, rem_in} - dsr) : rem_in;
                r_q[j]   <= q_in | (ge ? (QW'(1) << (QW - 1 - j)) : QW'(0));
                r_ovf[j] <= ovf_in;
            end
        end
    end

    always_comb begin
        h_sat = r_ovf[QW-1] ? '1 : r_q[QW-1];
        cm1   = i_cells - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_home <= (CW'(h_sat) > cm1) ? QW'(cm1) : h_sat;
        end
    end

    assign o_home = r_home;

endmodule

FILE: rtl/periodic_cell_neighbor_bins_unit.sv
// ----------------------------------------------------------------------------
// periodic_cell_neighbor_bins_unit
// result path: divider (multiply, restoring steps, clamp), axis sets, products,
//   expander, output register
// throughput: one result beat per cycle while the receiver is ready; a particle
//   yields nx*ny*nz result beats (1 to 27), which bounds the sustained input rate;
//   input beats enter every cycle only until the pipe fills
// reset: synchronous active low, cells = 1 and box = 1.0, pipeline empty
// ----------------------------------------------------------------------------
module periodic_cell_neighbor_bins_unit #(
    parameter int CELLS_MAX = pcnb_pkg::CELLS_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcnb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcnb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // particle position channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pcnb_pkg::POS_W-1:0]      i_pos_x,
    input  logic [pcnb_pkg::POS_W-1:0]      i_pos_y,
    input  logic [pcnb_pkg::POS_W-1:0]      i_pos_z,
    // neighbor cell channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pcnb_pkg::IDX_W-1:0]      o_home_cell,
    output logic [pcnb_pkg::IDX_W-1:0]      o_neighbor_cell,
    output logic                            o_last
);
    import pcnb_pkg::*;

    localparam int CW        = $clog2(CELLS_MAX + 1);
    localparam int QW        = (CELLS_MAX > 1) ? $clog2(CELLS_MAX) : 1;
    localparam int DIV_DEPTH = QW + 2;            // multiply, QW steps, clamp
    localparam int DEPTH     = DIV_DEPTH + 2;     // plus axis sets, products
    localparam int SXW       = 2 * CW;
    localparam int LW        = 3 * CW;
    localparam int SW        = (LW > IDX_W) ? LW : IDX_W;

    typedef struct packed {
        logic [1:0]    n;
        logic [QW-1:0] l0;
        logic [QW-1:0] l1;
        logic [QW-1:0] l2;
    } t_axis_set;

    // sorted distinct cells {h-1, h, h+1} with periodic wrap
    function automatic t_axis_set axis_set(input logic [QW-1:0] h, input logic [CW-1:0] c);
        t_axis_set s;
        logic [CW-1:0] hc;
        hc   = CW'(h);
        s.n  = 2'd3;
        s.l0 = h - QW'(1);
        s.l1 = h;
        s.l2 = h + QW'(1);
        if (c == CW'(1)) begin
            s.n  = 2'd1;
            s.l0 = '0;
            s.l1 = '0;
            s.l2 = '0;
        end else if (c == CW'(2)) begin
            s.n  = 2'd2;
            s.l0 = '0;
            s.l1 = QW'(1);
            s.l2 = '0;
        end else if (hc == '0) begin
            // left neighbor wraps to the top cell
            s.l0 = '0;
            s.l1 = QW'(1);
            s.l2 = QW'(c - CW'(1));
        end else if (hc == c - CW'(1)) begin
            // right neighbor wraps to cell zero
            s.l0 = '0;
            s.l1 = QW'(c - CW'(2));
            s.l2 = h;
        end
        return s;
    endfunction

    // ---------------- configuration registers ----------------
    logic [CREG_W-1:0] r_cells [3];
    logic [BOX_W-1:0]  r_box   [3];
    logic [CW-1:0]     c_eff   [3];
    logic [BOX_W-1:0]  b_eff   [3];
    logic [SXW-1:0]    r_sxy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cells[k] <= CELLS_RST;
                r_box[k]   <= BOX_RST;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CELLS_X: r_cells[0] <= i_cfg_data[CREG_W-1:0];
                CFG_CELLS_Y: r_cells[1] <= i_cfg_data[CREG_W-1:0];
                CFG_CELLS_Z: r_cells[2] <= i_cfg_data[CREG_W-1:0];
                CFG_BOX_X:   r_box[0]   <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_Y:   r_box[1]   <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_Z:   r_box[2]   <= i_cfg_data[BOX_W-1:0];
                default:     ;
            endcase
        end
    end

    // zero cells acts as one, counts above the maximum saturate, zero box acts as one
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_cells[k] == '0) begin
                c_eff[k] = CW'(1);
            end else if (32'(r_cells[k]) > CELLS_MAX) begin
                c_eff[k] = CW'(CELLS_MAX);
            end else begin
                c_eff[k] = CW'(r_cells[k]);
            end
            b_eff[k] = (r_box[k] == '0) ? BOX_W'(1) : r_box[k];
        end
    end

    // xy plane size, only read deep in the pipe
    always_ff @(posedge i_clk) begin
        r_sxy <= SXW'(c_eff[0]) * SXW'(c_eff[1]);
    end

    // ---------------- pipeline control ----------------
    logic [DEPTH-1:0] r_vld;
    logic             en;
    logic             accept;
    logic             load;
    logic             emit;
    logic             is_last;
    logic             r_busy;
    logic             r_o_valid;

    // whole pipe advances unless the final stage holds a particle the expander cannot take
    assign load    = r_vld[DEPTH-1] && (!r_busy || (emit && is_last));
    assign en      = !r_vld[DEPTH-1] || load;
    assign accept  = i_valid && en;
    assign o_ready = en;

    // ---------------- home cell per axis ----------------
    logic [POS_W-1:0] pos_in [3];
    logic [QW-1:0]    h_div  [3];

    assign pos_in[0] = i_pos_x;
    assign pos_in[1] = i_pos_y;
    assign pos_in[2] = i_pos_z;

    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
        pcnb_axis_div #(
            .CELLS_MAX (CELLS_MAX)
        ) u_div (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_pos   (pos_in[ax]),
            .i_cells (c_eff[ax]),
            .i_box   (b_eff[ax]),
            .o_home  (h_div[ax])
        );
    end

    // ---------------- axis neighbor sets ----------------
    logic [QW-1:0] r_l [3][3];
    logic [1:0]    r_n [3];
    logic [QW-1:0] r_h [3];
    t_axis_set     set_c [3];

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            set_c[ax] = axis_set(h_div[ax], c_eff[ax]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ax = 0; ax < 3; ax++) begin
                r_l[ax][0] <= set_c[ax].l0;
                r_l[ax][1] <= set_c[ax].l1;
                r_l[ax][2] <= set_c[ax].l2;
                r_n[ax]    <= set_c[ax].n;
                r_h[ax]    <= h_div[ax];
            end
        end
    end

    // ---------------- row and plane offsets ----------------
    logic [QW-1:0] r_m_lx [3];
    logic [SW-1:0] r_m_yt [3];
    logic [SW-1:0] r_m_zt [3];
    logic [1:0]    r_m_n  [3];
    logic [QW-1:0] r_m_hx;
    logic [SW-1:0] r_m_hyt;
    logic [SW-1:0] r_m_hzt;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m_lx[k] <= r_l[0][k];
                r_m_yt[k] <= SW'(r_l[1][k]) * SW'(c_eff[0]);
                r_m_zt[k] <= SW'(r_l[2][k]) * SW'(r_sxy);
                r_m_n[k]  <= r_n[k];
            end
            r_m_hx  <= r_h[0];
            r_m_hyt <= SW'(r_h[1]) * SW'(c_eff[0]);
            r_m_hzt <= SW'(r_h[2]) * SW'(r_sxy);
        end
    end

    // ---------------- neighbor expander ----------------
    logic [QW-1:0]    r_e_lx [3];
    logic [SW-1:0]    r_e_yt [3];
    logic [SW-1:0]    r_e_zt [3];
    logic [1:0]       r_e_n  [3];
    logic [1:0]       r_cnt  [3];
    logic [IDX_W-1:0] r_e_home;
    logic [SW-1:0]    home_sum;
    logic [SW-1:0]    nb_sum;
    logic [2:0]       at_end;
    logic [IDX_W-1:0] r_o_home;
    logic [IDX_W-1:0] r_o_nb;
    logic             r_o_last;

    // a beat leaves the expander when the output register is free or draining
    assign emit = r_busy && (!r_o_valid || i_ready);

    always_comb begin
        home_sum = SW'(r_m_hx) + r_m_hyt + r_m_hzt;
        nb_sum   = SW'(r_e_lx[r_cnt[0]]) + r_e_yt[r_cnt[1]] + r_e_zt[r_cnt[2]];
        for (int k = 0; k < 3; k++) begin
            at_end[k] = (r_cnt[k] == r_e_n[k] - 2'd1);
        end
        is_last = &at_end;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (en) begin
                r_vld <= {r_vld[DEPTH-2:0], accept};
            end

            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end

            if (load) begin
                r_busy <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_cnt[k] <= '0;
                end
            end else if (emit) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                // x fastest, then y, then z
                r_cnt[0] <= at_end[0] ? 2'd0 : r_cnt[0] + 2'd1;
                if (at_end[0]) begin
                    r_cnt[1] <= at_end[1] ? 2'd0 : r_cnt[1] + 2'd1;
                end
                if (at_end[0] && at_end[1]) begin
                    r_cnt[2] <= at_end[2] ? 2'd0 : r_cnt[2] + 2'd1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < 3; k++) begin
                r_e_lx[k] <= r_m_lx[k];
                r_e_yt[k] <= r_m_yt[k];
                r_e_zt[k] <= r_m_zt[k];
                r_e_n[k]  <= r_m_n[k];
            end
            r_e_home <= home_sum[IDX_W-1:0];
        end
        if (emit) begin
            r_o_home <= r_e_home;
            r_o_nb   <= nb_sum[IDX_W-1:0];
            r_o_last <= is_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_home_cell     = r_o_home;
    assign o_neighbor_cell = r_o_nb;
    assign o_last          = r_o_last;

endmodule

FILE: rtl/pcnb_checker.sv
// ----------------------------------------------------------------------------
// pcnb_checker
// port level checks of the neighbor cell result channel
// ----------------------------------------------------------------------------
module pcnb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [pcnb_pkg::IDX_W-1:0]      o_home_cell,
    input logic [pcnb_pkg::IDX_W-1:0]      o_neighbor_cell,
    input logic                            o_last
);
    import pcnb_pkg::*;

    logic [4:0]       r_cnt;
    logic             r_in_run;
    logic [IDX_W-1:0] r_prev_home;
    logic             out_beat;

    assign out_beat = o_valid && i_ready;

    // track beats of the particle in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_in_run    <= 1'b0;
            r_prev_home <= '0;
        end else if (out_beat) begin
            r_cnt       <= o_last ? 5'd0 : r_cnt + 5'd1;
            r_in_run    <= !o_last;
            r_prev_home <= o_home_cell;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_home_cell)
                                && $stable(o_neighbor_cell) && $stable(o_last))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_home_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_in_run |-> o_home_cell == r_prev_home)
        else $error("home cell changed within one particle");

    a_max_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && (r_cnt == 5'(MAX_RESULTS - 1)) |-> o_last)
        else $error("more than 27 beats for one particle");

endmodule

bind periodic_cell_neighbor_bins_unit pcnb_checker u_pcnb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_home_cell     (o_home_cell),
    .o_neighbor_cell (o_neighbor_cell),
    .o_last          (o_last)
);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the periodic cell neighbor unit: every particle position beat is
// mapped by a local model to its home cell and the sorted, wrapped and
// de-duplicated 3x3x3 neighborhood; every result beat is compared in order
// ----------------------------------------------------------------------------
module tb;

    import pcnb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 20;    // divider latency plus margin

    // register index of each axis, x y z
    localparam t_cfg_reg CELLS_REG [3] = '{CFG_CELLS_X, CFG_CELLS_Y, CFG_CELLS_Z};
    localparam t_cfg_reg BOX_REG   [3] = '{CFG_BOX_X, CFG_BOX_Y, CFG_BOX_Z};

    typedef struct packed {
        logic [IDX_W-1:0] home;
        logic [IDX_W-1:0] nbr;
        logic             last;
    } t_nbr_beat;

    // dut ports, inputs known from time zero
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_valid         = 1'b0;
    logic                  o_ready;
    logic [POS_W-1:0]      i_pos_x         = '0;
    logic [POS_W-1:0]      i_pos_y         = '0;
    logic [POS_W-1:0]      i_pos_z         = '0;
    logic                  o_valid;
    logic                  i_ready         = 1'b0;
    logic [IDX_W-1:0]      o_home_cell;
    logic [IDX_W-1:0]      o_neighbor_cell;
    logic                  o_last;

    // local copy of the register file, kept by the monitor
    logic [CREG_W-1:0] cells_reg [3];
    logic [BOX_W-1:0]  box_reg   [3];

    // neighborhood beats still owed by the block, oldest first
    t_nbr_beat nbr_q [$];

    int fail_count = 0;
    int cycle_count = 0;
    bit no_idle = 1'b0;     // both sides run without gaps while set
    int hold_left = 0;      // long receiver hold-off, in cycles
    int stall_left = 0;     // per-beat receiver stall, in cycles

    periodic_cell_neighbor_bins_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_home_cell     (o_home_cell),
        .o_neighbor_cell (o_neighbor_cell),
        .o_last          (o_last)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // neighborhood model
    // ------------------------------------------------------------------------

    // a count of zero acts as one, counts above the maximum saturate
    function automatic int eff_cells(input logic [CREG_W-1:0] r);
        int c;
        c = int'(r);
        if (c == 0) c = 1;
        if (c > CELLS_MAX_DEF) c = CELLS_MAX_DEF;
        return c;
    endfunction

    // floor(c * pos / box), a zero box acts as the smallest box,
    // positions at or past the box edge land in the top cell
    function automatic int home_bin(input logic [POS_W-1:0] p, input int c,
                                    input logic [BOX_W-1:0] b);
        longint unsigned q;
        longint unsigned d;
        d = (b == '0) ? 64'd1 : 64'(b);
        q = (64'(c) * 64'(p)) / d;
        if (q > 64'(c - 1)) q = 64'(c - 1);
        return int'(q);
    endfunction

    // sorted distinct members of {h-1, h, h+1} modulo c, returns how many
    function automatic int axis_span(input int h, input int c, output int lst [3]);
        int v [3];
        int t;
        int n;
        v[0] = (h + c - 1) % c;
        v[1] = h;
        v[2] = (h + 1) % c;
        if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
        if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
        if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
        lst = '{0, 0, 0};
        n = 0;
        for (int i = 0; i < 3; i++) begin
            if (n == 0 || lst[n-1] != v[i]) begin
                lst[n] = v[i];
                n++;
            end
        end
        return n;
    endfunction

    // queue every neighborhood beat of one particle, x fastest, z slowest
    function automatic void predict_neighbors(input logic [POS_W-1:0] px,
                                              input logic [POS_W-1:0] py,
                                              input logic [POS_W-1:0] pz);
        int cx, cy, cz, hx, hy, hz, nx, ny, nz, k, total;
        int lx [3];
        int ly [3];
        int lz [3];
        longint unsigned sxy, home, idx;
        t_nbr_beat beat;
        cx = eff_cells(cells_reg[0]);
        cy = eff_cells(cells_reg[1]);
        cz = eff_cells(cells_reg[2]);
        hx = home_bin(px, cx, box_reg[0]);
        hy = home_bin(py, cy, box_reg[1]);
        hz = home_bin(pz, cz, box_reg[2]);
        nx = axis_span(hx, cx, lx);
        ny = axis_span(hy, cy, ly);
        nz = axis_span(hz, cz, lz);
        sxy = 64'(cx) * 64'(cy);
        home = 64'(hx) + 64'(hy) * 64'(cx) + 64'(hz) * sxy;
        total = nx * ny * nz;
        k = 0;
        for (int c = 0; c < nz; c++) begin
            for (int b = 0; b < ny; b++) begin
                for (int a = 0; a < nx; a++) begin
                    idx = 64'(lx[a]) + 64'(ly[b]) * 64'(cx) + 64'(lz[c]) * sxy;
                    beat.home = home[IDX_W-1:0];
                    beat.nbr  = idx[IDX_W-1:0];
                    beat.last = (k + 1 == total);
                    nbr_q = {nbr_q, beat};
                    k++;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor: tracks register writes, predicts on input beats and checks
    // result beats, all sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_nbr_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                cells_reg[i] = CELLS_RST;
                box_reg[i]   = BOX_RST;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_CELLS_X: cells_reg[0] = i_cfg_data[CREG_W-1:0];
                    CFG_CELLS_Y: cells_reg[1] = i_cfg_data[CREG_W-1:0];
                    CFG_CELLS_Z: cells_reg[2] = i_cfg_data[CREG_W-1:0];
                    CFG_BOX_X:   box_reg[0]   = i_cfg_data[BOX_W-1:0];
                    CFG_BOX_Y:   box_reg[1]   = i_cfg_data[BOX_W-1:0];
                    CFG_BOX_Z:   box_reg[2]   = i_cfg_data[BOX_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready)
                predict_neighbors(i_pos_x, i_pos_y, i_pos_z);
            if (o_valid && i_ready) begin
                // next stall of the receiver, applied from the falling edge
                stall_left = no_idle ? 0 : $urandom_range(0, 8);
                if (nbr_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected beat: home %0d nbr %0d last %0b",
                                 o_home_cell, o_neighbor_cell, o_last);
                end else begin
                    want = nbr_q.pop_front();
                    if (o_home_cell !== want.home || o_neighbor_cell !== want.nbr ||
                        o_last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: home %0d/%0d nbr %0d/%0d last %0b/%0b",
                                      " (expected/actual)"},
                                     want.home, o_home_cell, want.nbr, o_neighbor_cell,
                                     want.last, o_last);
                    end
                end
            end
        end
    end

    // receiver: long hold-off first, then the per-beat stall
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // shared drivers; each returns at a rising edge
    // ------------------------------------------------------------------------

    // one position beat; valid stays up into the next call when no gap is drawn
    task automatic send_pos(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [POS_W-1:0] pz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic sender_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every owed beat, then let the pipeline settle
    task automatic drain();
        while (nbr_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // cells count goes in the low bits, the upper bits carry noise
    task automatic set_axis(input int a, input logic [CREG_W-1:0] cells,
                            input logic [BOX_W-1:0] box);
        logic [CFG_DATA_W-1:0] d;
        d = $urandom;
        d[CREG_W-1:0] = cells;
        write_reg(CELLS_REG[a], d);
        write_reg(BOX_REG[a], box);
    endtask

    // mostly inside the box, now and then anywhere
    function automatic logic [POS_W-1:0] rand_pos(input logic [BOX_W-1:0] b);
        longint unsigned d;
        d = (b == '0) ? 64'd1 : 64'(b);
        if ($urandom_range(0, 9) < 8)
            return POS_W'(64'($urandom) % d);
        return $urandom;
    endfunction

    function automatic logic [CREG_W-1:0] rand_cells();
        case ($urandom_range(0, 9))
            0:       return CREG_W'(1);
            1:       return CREG_W'(2);
            2:       return CREG_W'(3);
            3:       return CREG_W'(64);
            4:       return CREG_W'($urandom_range(0, 127));   // includes out-of-range counts
            default: return CREG_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [BOX_W-1:0] rand_box();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 16);
            3, 4:    return $urandom_range(1, 32'h0080_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_pos(rand_pos(box_reg[0]), rand_pos(box_reg[1]), rand_pos(box_reg[2]));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // one cell per axis after reset: every particle sees only cell 0
    task automatic test_reset_defaults();
        send_pos('0, '0, '0);
        send_pos('1, '1, '1);
        send_pos(32'h0000_8000, 32'h0001_0000, 32'hAAAA_5555);
        sender_idle();
        drain();
    endtask

    task automatic test_directed_cases();
        // full 27 neighborhood, home cells at both ends, position at and past the edge
        for (int a = 0; a < 3; a++) set_axis(a, 7'd3, 32'h0003_0000);
        send_pos('0, 32'h0001_FFFF, 32'h0002_FFFF);
        send_pos(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_pos('1, 32'h0001_8000, '0);
        sender_idle();
        drain();

        // two cells drop wrapped duplicates, one cell collapses the axis
        set_axis(0, 7'd2, 32'h0002_0000);
        set_axis(1, 7'd1, 32'h0000_0001);
        set_axis(2, 7'd64, '1);
        send_pos(32'h0001_FFFF, 32'h0000_0005, 32'hFFFF_FFFE);
        send_pos('0, '0, '0);
        send_pos(32'h0001_0000, '1, 32'h8000_0000);
        sender_idle();
        drain();

        // largest grid and box, top home index
        for (int a = 0; a < 3; a++) set_axis(a, 7'd64, '1);
        send_pos('0, '0, '0);
        send_pos(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
        send_pos(32'h7FFF_FFFF, 32'h8000_0000, '1);
        sender_idle();
        drain();

        // zero cell count, oversized counts, zero boxes
        set_axis(0, 7'd0, '0);
        set_axis(1, 7'd127, 32'h0040_0000);
        set_axis(2, 7'd65, '0);
        send_pos('0, 32'h0000_0001, '0);
        send_pos(32'h0000_0005, 32'h003F_FFFF, 32'h0000_0001);
        send_pos('0, 32'h0012_3456, '0);
        sender_idle();
        drain();

        // smallest nonzero box: only position zero stays in cell 0
        set_axis(0, 7'd4, 32'h0000_0001);
        set_axis(1, 7'd5, 32'h0000_0001);
        set_axis(2, 7'd6, 32'h0000_0001);
        send_pos('0, '0, '0);
        send_pos(32'h0000_0001, '0, 32'h5555_AAAA);
        sender_idle();
        drain();
    endtask

    // several random settings, the first one with no idling on either side
    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            for (int a = 0; a < 3; a++) set_axis(a, rand_cells(), rand_box());
            no_idle = (phase == 0);
            send_random(32);
            sender_idle();
            drain();
            no_idle = 1'b0;
        end
    endtask

    // receiver holds off while the sender keeps offering: the block must stall
    task automatic test_stalled_output();
        for (int a = 0; a < 3; a++) set_axis(a, CREG_W'(3 + a), 32'h0010_0000);
        hold_left = 400;
        no_idle = 1'b1;
        send_random(30);
        sender_idle();
        no_idle = 1'b0;
        drain();
    endtask

    // sender waits for every owed beat between two bursts
    task automatic test_sender_pause();
        for (int a = 0; a < 3; a++) set_axis(a, rand_cells(), rand_box());
        send_random(12);
        sender_idle();
        drain();
        send_random(12);
        sender_idle();
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_cases();
        test_random_settings();
        test_stalled_output();
        test_sender_pause();

        fail_count += nbr_q.size();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
